// ===== design/mdq_pkg.sv =====
// ----------------------------------------------------------------------------
// mdq_pkg
// Shared constants, operation and status codes, and controller/datapath
// interface structs for the shared-pool multi-deque.
// ----------------------------------------------------------------------------
package mdq_pkg;

  localparam int NUM_QUEUES = 256;
  localparam int POOL_DEPTH = 1024;
  localparam int DATA_WIDTH = 32;

  localparam int QUEUE_W = $clog2(NUM_QUEUES);
  localparam int NODE_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);

  localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch the incoming item, reads address from input
    logic commit_push; // link the new node, write the result
    logic commit_pop;  // unlink the end node, write the result
    logic commit_err;  // error result only, no state change
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;   // latched op is a pop
    logic err;      // latched item fails (empty pop or full pool)
    logic out_free; // result register can take a new result this cycle
  } sts_t;

endpackage

// ===== design/mdq_ram.sv =====
// ----------------------------------------------------------------------------
// mdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/mdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdq_ctrl
// Sequencer: accept, link/check, optional node-read cycle for pops.
// ----------------------------------------------------------------------------
module mdq_ctrl
  import mdq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WORK;
        end
      end
      S_WORK: begin
        if (sts.err) begin
          if (sts.out_free) begin
            cmd.commit_err = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.is_pop) begin
          state_nxt = S_POP; // node reads in flight
        end else if (sts.out_free) begin
          cmd.commit_push = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.commit_pop = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/mdq_datapath.sv =====
// ----------------------------------------------------------------------------
// mdq_datapath
// Pointer and node memories, free-list bookkeeping and result register.
// ----------------------------------------------------------------------------
module mdq_datapath
  import mdq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic [1:0]                   in_op,
  input  logic [7:0]                   in_queue_index,
  input  logic signed [31:0]           in_push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_pop_value,
  output logic [1:0]                   out_status
);

  // latched item
  logic [1:0]            op_r;
  logic [QUEUE_W-1:0]    q_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [1:0]            status_r;
  logic                  from_free_r;

  // control state
  logic [NUM_QUEUES-1:0] queue_ne_r, queue_ne_nxt;
  logic [CNT_W-1:0]      free_top_r, free_top_nxt;
  logic [CNT_W-1:0]      fresh_count_r, fresh_count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // result payload
  logic signed [31:0]    out_pop_value_r;
  logic [1:0]            out_status_r;

  // memory ports
  logic [QUEUE_W-1:0]    ptr_rd_addr;
  logic                  head_we, tail_we;
  logic [NODE_W-1:0]     head_wd, tail_wd, head_rd, tail_rd;
  logic                  value_we;
  logic [DATA_WIDTH-1:0] value_rd;
  logic [NODE_W-1:0]     value_ra;
  logic                  next_we, prev_we;
  logic [NODE_W-1:0]     next_wa, next_wd, next_rd;
  logic [NODE_W-1:0]     prev_wa, prev_wd, prev_rd;
  logic                  free_we;
  logic [NODE_W-1:0]     free_rd, free_ra;
  logic [CNT_W-1:0]      free_top_dec;

  logic                  in_is_push, is_push, can_alloc, ne_q;
  logic [1:0]            in_status;
  logic [NODE_W-1:0]     n_push;

  assign in_is_push = (in_op == OP_PUSH_BACK) || (in_op == OP_PUSH_FRONT);
  assign is_push    = (op_r == OP_PUSH_BACK) || (op_r == OP_PUSH_FRONT);
  assign can_alloc  = (free_top_r != '0) || (fresh_count_r < CNT_W'(POOL_DEPTH));
  assign ne_q       = queue_ne_r[q_r];

  always_comb begin
    if (in_is_push) begin
      in_status = can_alloc ? ST_OK : ST_FULL;
    end else begin
      in_status = queue_ne_r[in_queue_index[QUEUE_W-1:0]] ? ST_OK : ST_EMPTY;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_op;
      q_r         <= in_queue_index[QUEUE_W-1:0];
      val_r       <= in_push_value[DATA_WIDTH-1:0];
      status_r    <= in_status;
      from_free_r <= (free_top_r != '0);
    end
  end

  // read addresses: pointers from the input on accept, else the latched queue
  assign ptr_rd_addr  = cmd.accept ? in_queue_index[QUEUE_W-1:0] : q_r;
  assign free_top_dec = free_top_r - CNT_W'(1);
  assign free_ra      = free_top_dec[NODE_W-1:0];
  assign value_ra     = (op_r == OP_POP_FRONT) ? head_rd : tail_rd;
  assign n_push       = from_free_r ? free_rd : fresh_count_r[NODE_W-1:0];

  // write side
  always_comb begin
    head_we  = 1'b0;
    tail_we  = 1'b0;
    head_wd  = n_push;
    tail_wd  = n_push;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    next_wa  = tail_rd;
    next_wd  = n_push;
    prev_wa  = n_push;
    prev_wd  = tail_rd;
    value_we = cmd.commit_push;
    free_we  = cmd.commit_pop && (free_top_r < CNT_W'(POOL_DEPTH));
    if (cmd.commit_push) begin
      if (!ne_q) begin
        head_we = 1'b1;
        tail_we = 1'b1;
      end else if (op_r == OP_PUSH_BACK) begin
        tail_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end else begin
        head_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = n_push;
        next_wd = head_rd;
        prev_wa = head_rd;
        prev_wd = n_push;
      end
    end else if (cmd.commit_pop && (head_rd != tail_rd)) begin
      if (op_r == OP_POP_FRONT) begin
        head_we = 1'b1;
        head_wd = next_rd;
      end else begin
        tail_we = 1'b1;
        tail_wd = prev_rd;
      end
    end
  end

  // bookkeeping
  always_comb begin
    queue_ne_nxt    = queue_ne_r;
    free_top_nxt    = free_top_r;
    fresh_count_nxt = fresh_count_r;
    if (cmd.commit_push) begin
      queue_ne_nxt[q_r] = 1'b1;
      if (from_free_r) begin
        free_top_nxt = free_top_dec;
      end else begin
        fresh_count_nxt = fresh_count_r + CNT_W'(1);
      end
    end else if (cmd.commit_pop) begin
      if (head_rd == tail_rd) begin
        queue_ne_nxt[q_r] = 1'b0;
      end
      if (free_we) begin
        free_top_nxt = free_top_r + CNT_W'(1);
      end
    end
  end

  // result register
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.is_pop   = !is_push;
  assign sts.err      = (status_r != ST_OK);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit_push || cmd.commit_pop || cmd.commit_err) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_push || cmd.commit_pop || cmd.commit_err) begin
      out_status_r    <= status_r;
      out_pop_value_r <= cmd.commit_pop ? 32'(signed'(value_rd)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_ne_r    <= '0;
      free_top_r    <= '0;
      fresh_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      queue_ne_r    <= queue_ne_nxt;
      free_top_r    <= free_top_nxt;
      fresh_count_r <= fresh_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

  // memories
  mdq_ram #(.WIDTH(NODE_W), .DEPTH(NUM_QUEUES)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(q_r), .wr_data(head_wd),
    .rd_addr(ptr_rd_addr), .rd_data(head_rd)
  );

  mdq_ram #(.WIDTH(NODE_W), .DEPTH(NUM_QUEUES)) u_tail (
    .clk(clk), .wr_en(tail_we), .wr_addr(q_r), .wr_data(tail_wd),
    .rd_addr(ptr_rd_addr), .rd_data(tail_rd)
  );

  mdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_value (
    .clk(clk), .wr_en(value_we), .wr_addr(n_push), .wr_data(val_r),
    .rd_addr(value_ra), .rd_data(value_rd)
  );

  mdq_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_next (
    .clk(clk), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
    .rd_addr(head_rd), .rd_data(next_rd)
  );

  mdq_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_prev (
    .clk(clk), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
    .rd_addr(tail_rd), .rd_data(prev_rd)
  );

  mdq_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_free (
    .clk(clk), .wr_en(free_we), .wr_addr(free_top_r[NODE_W-1:0]), .wr_data(value_ra),
    .rd_addr(free_ra), .rd_data(free_rd)
  );

  // checks
  a_free_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= CNT_W'(POOL_DEPTH))
    else $error("free stack count beyond pool depth");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_count_r <= CNT_W'(POOL_DEPTH))
    else $error("fresh node count beyond pool depth");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit_push || cmd.commit_pop) |-> (status_r == ST_OK))
    else $error("state changed by a failing item");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit_push || cmd.commit_pop || cmd.commit_err))
    else $error("result raised without a commit");

  a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.commit_push, cmd.commit_pop, cmd.commit_err, cmd.accept}) <= 1)
    else $error("overlapping commands");

endmodule

// ===== design/multi_deque_shared_pool.sv =====
// ----------------------------------------------------------------------------
// multi_deque_shared_pool
// 256 double-ended queues sharing a pool of 1024 doubly linked nodes.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one item carries in_op (push back,
//   push front, pop front, pop back), in_queue_index and in_push_value.
//   Result channel (out_valid / out_stall): exactly one item per input,
//   out_pop_value (0 for pushes and failures) and out_status (ok, pop from
//   empty deque, pool full on push). A failing item changes no state.
//   Steps: a push does a pointer read, then a link write; a pop does a
//   pointer read, a node read, then an unlink; an error does a pointer
//   read, then a result write. The block works on one item at a time;
//   results appear the cycle after the final step.
//   The result register decouples the sides: a new item is taken while a
//   result still waits, but the final step holds while the receiver stalls
//   and the register is full.
//   Reset: all deques empty and the pool wholly unused; no clearing pass.
//   Freed nodes are reused most-recent first, ahead of unused nodes.
// ----------------------------------------------------------------------------
module multi_deque_shared_pool
  import mdq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_queue_index,
  input  logic signed [31:0] in_push_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_status
);

  cmd_t cmd; // sequencer commands
  sts_t sts; // datapath status

  // sequencer: idle -> work (link or check) -> pop node read, when needed
  mdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories, free list and result register
  mdq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_queue_index (in_queue_index),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status)
  );

endmodule

// ===== tb/tb_multi_deque_shared_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_deque_shared_pool
// Self-checking bench for the shared-pool multi-deque. A behavioural copy of
// the deques and the node pool predicts every result item; results are
// checked in order as they leave the block. Directed end cases come first,
// then a random mix on a few busy deques, then a run into pool exhaustion
// and back out of it.
// ----------------------------------------------------------------------------
module tb_multi_deque_shared_pool;
  import mdq_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int ITEMS_PER_SEG = 20;
  localparam int RANDOM_SEGS   = 10;
  localparam int HOT_QUEUES    = 6;

  typedef struct {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } deque_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = OP_PUSH_BACK;
  logic [7:0]         in_queue_index = '0;
  logic signed [31:0] in_push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pop_value;
  logic [1:0]         out_status;

  // Idling switches, flipped per phase by the tests.
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;

  // Results predicted but not yet seen on the result channel, oldest first.
  deque_result_t pending_results[$];

  // Behavioural copy of the deque state.
  logic [NODE_W-1:0]  head_of  [NUM_QUEUES];
  logic [NODE_W-1:0]  tail_of  [NUM_QUEUES];
  bit                 occupied [NUM_QUEUES];
  logic signed [31:0] node_val [POOL_DEPTH];
  logic [NODE_W-1:0]  node_nxt [POOL_DEPTH];
  logic [NODE_W-1:0]  node_prv [POOL_DEPTH];
  logic [NODE_W-1:0]  recycled [POOL_DEPTH];   // released nodes, last in first out
  int unsigned        recycled_cnt = 0;
  int unsigned        fresh_used   = 0;        // nodes ever taken from the unused region

  logic [7:0] hot_queues [HOT_QUEUES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_deque_shared_pool u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_queue_index (in_queue_index),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int unsigned nodes_in_use();
    return fresh_used - recycled_cnt;
  endfunction

  // Applies one operation to the behavioural deques and returns its result.
  // A failing item (empty pop, push with no node left) changes nothing.
  function automatic deque_result_t predict_deque_op(logic [1:0] op, logic [7:0] qi,
                                                     logic signed [31:0] value);
    deque_result_t     r;
    int unsigned       q;
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] h;
    logic [NODE_W-1:0] t;
    r.pop_value = '0;
    r.status    = ST_OK;
    q = qi % NUM_QUEUES;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      // freed nodes are reused, most recent first, before untouched ones
      if (recycled_cnt > 0) begin
        recycled_cnt--;
        n = recycled[recycled_cnt];
      end else if (fresh_used < POOL_DEPTH) begin
        n = NODE_W'(fresh_used);
        fresh_used++;
      end else begin
        r.status = ST_FULL;
      end
      if (r.status == ST_OK) begin
        node_val[n] = value;
        if (!occupied[q]) begin
          head_of[q]  = n;
          tail_of[q]  = n;
          occupied[q] = 1'b1;
        end else if (op == OP_PUSH_BACK) begin
          node_prv[n]          = tail_of[q];
          node_nxt[tail_of[q]] = n;
          tail_of[q]           = n;
        end else begin
          node_nxt[n]          = head_of[q];
          node_prv[head_of[q]] = n;
          head_of[q]           = n;
        end
      end
    end else if (!occupied[q]) begin
      r.status = ST_EMPTY;
    end else begin
      h = head_of[q];
      t = tail_of[q];
      n = (op == OP_POP_FRONT) ? h : t;
      r.pop_value = node_val[n];
      if (h == t) begin
        occupied[q] = 1'b0;
      end else if (op == OP_POP_FRONT) begin
        head_of[q] = node_nxt[h];
      end else begin
        tail_of[q] = node_prv[t];
      end
      recycled[recycled_cnt] = n;
      recycled_cnt++;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Drives one item and holds it until the block takes it. in_valid is left
  // high so that back-to-back items need no extra step.
  task automatic send_item(input logic [1:0] op, input logic [7:0] qi,
                           input logic signed [31:0] value);
    deque_result_t expected;
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_queue_index <= qi;
    in_push_value  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected = predict_deque_op(op, qi, value);
    pending_results.insert(pending_results.size(), expected);
  endtask

  // Stops sending until every predicted result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly one of a few busy deques so that they grow deep; the rest are
  // spread over the whole index range and mostly hit empty deques.
  function automatic logic [7:0] pick_queue();
    if ($urandom_range(99) < 75) return hot_queues[$urandom_range(HOT_QUEUES - 1)];
    return 8'($urandom_range(NUM_QUEUES - 1));
  endfunction

  function automatic logic [1:0] pick_push();
    return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  task automatic send_random_item(input int unsigned push_pct);
    logic [1:0] op;
    if ($urandom_range(99) < push_pct) op = pick_push();
    else op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    // pops carry a random value too; the block must ignore it
    send_item(op, pick_queue(), pick_value());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Both ends of one deque, extreme values, empty pops, the lowest and the
  // highest queue index, and reuse of freed nodes.
  task automatic test_directed_ends();
    send_item(OP_POP_FRONT,  8'd0,   32'sh1234_5678);   // empty deque
    send_item(OP_POP_BACK,   8'd255, -32'sd1);          // empty deque
    send_item(OP_PUSH_BACK,  8'd0,   32'sh7fff_ffff);
    send_item(OP_PUSH_BACK,  8'd0,   32'sh8000_0000);
    send_item(OP_PUSH_FRONT, 8'd0,   -32'sd1);
    send_item(OP_PUSH_FRONT, 8'd0,   32'sd0);
    send_item(OP_POP_FRONT,  8'd0,   32'sh7fff_ffff);
    send_item(OP_POP_BACK,   8'd0,   '0);
    send_item(OP_POP_BACK,   8'd0,   '0);
    send_item(OP_POP_FRONT,  8'd0,   '0);               // last node: deque goes empty
    send_item(OP_POP_FRONT,  8'd0,   '0);
    send_item(OP_PUSH_FRONT, 8'd255, 32'sh5555_5555);   // takes back a freed node
    send_item(OP_PUSH_BACK,  8'd255, 32'shaaaa_aaaa);
    send_item(OP_PUSH_BACK,  8'd170, 32'sh0f0f_0f0f);
    send_item(OP_POP_FRONT,  8'd255, 32'sh8000_0000);
    send_item(OP_POP_FRONT,  8'd255, '0);
    send_item(OP_POP_BACK,   8'd255, '0);
    send_item(OP_POP_BACK,   8'd170, '0);
    send_item(OP_POP_FRONT,  8'd85,  32'sh7fff_ffff);
  endtask

  // Segments with changing push bias; a run of segments with no idling on
  // either side; one pause before the last two segments until the block is empty.
  task automatic test_random_mix();
    int unsigned push_pct;
    bit          quiet;
    for (int i = 0; i < HOT_QUEUES; i++) hot_queues[i] = 8'($urandom_range(NUM_QUEUES - 1));
    for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
      quiet    = (seg >= 3 && seg < 7);
      gaps_on  = !quiet;
      stall_on = !quiet;
      case (seg % 3)
        0:       push_pct = 75;
        1:       push_pct = 50;
        default: push_pct = 30;
      endcase
      if (seg == 8) hold_until_drained();
      for (int k = 0; k < ITEMS_PER_SEG; k++) send_random_item(push_pct);
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Fills the pool, pushes into a full pool, then works at the boundary
  // where pops free nodes and pushes take them straight back.
  task automatic test_pool_exhaustion();
    while (nodes_in_use() < POOL_DEPTH) send_item(pick_push(), pick_queue(), pick_value());
    repeat (6) send_item(pick_push(), 8'($urandom_range(NUM_QUEUES - 1)), pick_value());
    repeat (40) send_random_item(50);
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result item with none expected (value %0d status %0d)",
                                out_pop_value, out_status));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status, out_status));
        if (out_pop_value !== want.pop_value)
          flag_mismatch($sformatf("pop_value expected %0d got %0d",
                                  want.pop_value, out_pop_value));
      end
    end
    out_stall <= stall_on && ($urandom_range(99) < 33);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_deque_shared_pool regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ends();
    hold_until_drained();
    test_random_mix();
    hold_until_drained();
    test_pool_exhaustion();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // wait for any stray result item to show up
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multi_deque_shared_pool regression: pass");
    end else begin
      $display("multi_deque_shared_pool regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mdq_pkg.sv
design/mdq_ram.sv
design/mdq_ctrl.sv
design/mdq_datapath.sv
design/multi_deque_shared_pool.sv
tb/tb_multi_deque_shared_pool.sv
